@@ rtl/hex_ascii_meter_frame_checker_macros.svh @@
// Assertion macros used by the frame checker's assertion file.
`ifndef HEX_ASCII_METER_FRAME_CHECKER_MACROS_SVH
`define HEX_ASCII_METER_FRAME_CHECKER_MACROS_SVH

// Clocked on clk_i, muted while rst_ni is low.
`define HAMFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked around reset.
`define HAMFC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/hamfc_pkg.sv @@
// Types and constants shared by the hex ASCII meter frame checker.
`default_nettype none

package hamfc_pkg;

  localparam int unsigned ChWidth  = 8;
  localparam int unsigned IdWidth  = 64;
  localparam int unsigned LenWidth = 16;
  localparam int unsigned PosWidth = 18;

  // Character offsets of the fixed header
  localparam logic [PosWidth-1:0] PosIdFirst   = 18'd2;
  localparam logic [PosWidth-1:0] PosIdLast    = 18'd9;
  localparam logic [PosWidth-1:0] PosRestart0  = 18'd14;
  localparam logic [PosWidth-1:0] PosRestart1  = 18'd15;
  localparam logic [PosWidth-1:0] PosCtrlLo    = 18'd17;
  localparam logic [PosWidth-1:0] PosLenLo     = 18'd19;
  localparam logic [PosWidth-1:0] PosLenHi     = 18'd21;
  localparam logic [PosWidth-1:0] PosDataStart = 18'd22;

  localparam logic [ChWidth-1:0] Ch1 = 8'h31;
  localparam logic [ChWidth-1:0] Ch6 = 8'h36;
  localparam logic [ChWidth-1:0] Ch8 = 8'h38;

  // Configuration register indexes
  localparam logic CfgExpectedId = 1'b0;
  localparam logic CfgMaxLength  = 1'b1;

  localparam logic [LenWidth-1:0] MaxLengthReset = 16'd97;

  typedef enum logic [2:0] {
    VerdictOk       = 3'd0,
    VerdictStart    = 3'd1,
    VerdictRestart  = 3'd2,
    VerdictId       = 3'd3,
    VerdictOverload = 3'd4,
    VerdictEndCode  = 3'd5,
    VerdictChecksum = 3'd6
  } verdict_e;

  typedef struct packed {
    logic               frame_start;
    logic [ChWidth-1:0] ch;
  } item_t;

  typedef struct packed {
    verdict_e            verdict;
    logic [7:0]          ctrl_code;
    logic [LenWidth-1:0] data_length;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/hamfc_core.sv @@
// Frame state and verdict logic: one character per step.
`default_nettype none

module hamfc_core import hamfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire item_t               item_i,
  input  wire logic [IdWidth-1:0]  expected_id_i,
  input  wire logic [LenWidth-1:0] max_length_i,
  output logic                     res_valid_o,
  output res_t                     res_o
);

  function automatic logic [3:0] hex_nibble(input logic [ChWidth-1:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) n = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) n = c[3:0] + 4'd9;
    return n;
  endfunction

  logic                active_q, active_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [3:0]          hn_q, hn_d;
  logic [7:0]          sum_q, sum_d;
  logic                idm_q, idm_d;
  logic [LenWidth-1:0] len_q, len_d;
  logic [7:0]          ctl_q, ctl_d;
  logic                sm_q, sm_d;

  logic [PosWidth-1:0] pos, cs;
  logic [3:0]          hn, nib;
  logic [7:0]          sum, ctl, byte_v, exp_ch;
  logic                idm, sm, run, emit;
  logic [LenWidth-1:0] len;
  logic [2:0]          id_sel;
  verdict_e            verdict;

  always_comb begin
    // a frame start discards whatever frame was running
    pos = item_i.frame_start ? '0 : pos_q;
    hn  = item_i.frame_start ? '0 : hn_q;
    sum = item_i.frame_start ? '0 : sum_q;
    idm = item_i.frame_start ? 1'b0 : idm_q;
    len = item_i.frame_start ? '0 : len_q;
    ctl = item_i.frame_start ? '0 : ctl_q;
    sm  = item_i.frame_start ? 1'b0 : sm_q;

    nib    = hex_nibble(item_i.ch);
    byte_v = pos[0] ? {hn, nib} : 8'd0;
    cs     = {1'b0, len, 1'b0} + PosDataStart;  // checksum offset
    id_sel = 3'd7 - (pos[2:0] - 3'd2);
    exp_ch = expected_id_i[{id_sel, 3'b000} +: 8];

    pos_d = pos + 18'd1;
    hn_d  = pos[0] ? hn : nib;
    sum_d = sum;
    idm_d = idm;
    len_d = len;
    ctl_d = ctl;
    sm_d  = sm;
    emit    = 1'b0;
    verdict = VerdictOk;

    if (pos[0] && (pos <= PosLenHi || pos < cs)) sum_d = sum + byte_v;

    if (pos == '0) begin
      if (item_i.ch != Ch6) begin emit = 1'b1; verdict = VerdictStart; end
    end else if (pos == 18'd1) begin
      if (item_i.ch != Ch8) begin emit = 1'b1; verdict = VerdictStart; end
    end else if (pos >= PosIdFirst && pos <= PosIdLast) begin
      if (item_i.ch != exp_ch) idm_d = 1'b1;
    end else if (pos == PosRestart0) begin
      if (item_i.ch != Ch6) begin emit = 1'b1; verdict = VerdictRestart; end
    end else if (pos == PosRestart1) begin
      if (item_i.ch != Ch8) begin
        emit = 1'b1; verdict = VerdictRestart;
      end else if (idm) begin
        emit = 1'b1; verdict = VerdictId;
      end
    end else if (pos == PosCtrlLo) begin
      ctl_d = byte_v;
    end else if (pos == PosLenLo) begin
      len_d = {8'd0, byte_v};
    end else if (pos == PosLenHi) begin
      len_d = {byte_v, len[7:0]};
      if ({byte_v, len[7:0]} > max_length_i) begin emit = 1'b1; verdict = VerdictOverload; end
    end else if (pos >= PosDataStart) begin
      if (pos == cs + 18'd1) begin
        sm_d = (byte_v == sum);
      end else if (pos == cs + 18'd2) begin
        if (item_i.ch != Ch1) begin emit = 1'b1; verdict = VerdictEndCode; end
      end else if (pos == cs + 18'd3) begin
        emit    = 1'b1;
        verdict = (item_i.ch != Ch6) ? VerdictEndCode : (sm ? VerdictOk : VerdictChecksum);
      end
    end

    run      = step_i && (item_i.frame_start || active_q);
    active_d = run ? !emit : active_q;

    res_valid_o       = run && emit;
    res_o.verdict     = verdict;
    res_o.ctrl_code   = ctl_d;
    res_o.data_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      hn_q     <= '0;
      sum_q    <= '0;
      idm_q    <= 1'b0;
      len_q    <= '0;
      ctl_q    <= '0;
      sm_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      if (run) begin
        pos_q <= pos_d;
        hn_q  <= hn_d;
        sum_q <= sum_d;
        idm_q <= idm_d;
        len_q <= len_d;
        ctl_q <= ctl_d;
        sm_q  <= sm_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/hex_ascii_meter_frame_checker.sv @@
// Top level of the ASCII-hex meter frame checker.
//
//   channel | direction | handshake                     | payload
//   s_axis  | in        | s_axis_tvalid / s_axis_tready | tdata: ch; tuser: frame_start
//   m_axis  | out       | m_axis_tvalid / m_axis_tready | tdata: verdict, control, length
//   cfg     | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One character per cycle while m_axis is not stalled; a verdict passes the input register,
// then the result register, on its way to m_axis. The frame checks sit between the two.
// Reset clears the frame state and sets expected_id to 0 and max_length to 97.
// A stalled m_axis holds the result; the input register still takes one more item.
`default_nettype none

module hex_ascii_meter_frame_checker import hamfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] ch
  input  wire logic                s_axis_tuser,   // [0] frame_start
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,   // [2:0] verdict, [10:3] ctrl_code,
                                                   // [26:11] data_length, [31:27] zero
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [IdWidth-1:0]  cfg_data_i
);

  logic                in_valid_q, in_valid_d;
  item_t               in_item_q;
  logic                out_valid_q, out_valid_d;
  res_t                out_res_q;
  logic [IdWidth-1:0]  expected_id_q;
  logic [LenWidth-1:0] max_length_q;
  logic                step, res_valid;
  res_t                res;

  assign cfg_ready_o   = 1'b1;
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) in_valid_d = 1'b1;
    else if (step)                      in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (res_valid)          out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      expected_id_q <= '0;
      max_length_q  <= MaxLengthReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgExpectedId: expected_id_q <= cfg_data_i;
          CfgMaxLength:  max_length_q  <= cfg_data_i[LenWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= '{frame_start: s_axis_tuser, ch: s_axis_tdata};
    end
    if (res_valid) out_res_q <= res;
  end

  hamfc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (in_item_q),
    .expected_id_i (expected_id_q),
    .max_length_i  (max_length_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q.data_length, out_res_q.ctrl_code,
                          out_res_q.verdict};

endmodule

`default_nettype wire

@@ rtl/hamfc_checker.sv @@
// Port-level assertions for the frame checker, bound to the top level.
`default_nettype none

`include "hex_ascii_meter_frame_checker_macros.svh"

module hamfc_checker import hamfc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  logic [2:0] out_verdict;
  logic       header_fail;

  assign out_verdict = m_axis_tdata[2:0];
  assign header_fail = (out_verdict == VerdictStart) || (out_verdict == VerdictRestart) ||
                       (out_verdict == VerdictId);

  // nothing leaves the block in the first cycle after reset
  `HAMFC_ASSERT_RST(a_no_out_after_reset, $rose(rst_ni) |-> !m_axis_tvalid, "early result")

  `HAMFC_ASSERT(a_verdict_code, m_axis_tvalid |-> (out_verdict <= VerdictChecksum), "bad verdict")

  `HAMFC_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[31:27] == 5'd0), "pad not zero")

  // header failures end the frame before the control and length fields
  `HAMFC_ASSERT(a_early_fields_zero, (m_axis_tvalid && header_fail) |-> (m_axis_tdata[26:3] == '0), "fields set")

  `HAMFC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stall")

endmodule

bind hex_ascii_meter_frame_checker hamfc_checker u_hamfc_checker (.*);

`default_nettype wire

@@ tb/hex_ascii_meter_frame_checker_scoreboard.sv @@
// Scoreboard for the frame checker: follows every taken character and compares the verdicts.
module hex_ascii_meter_frame_checker_scoreboard import hamfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [31:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [IdWidth-1:0] cfg_data_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 verdicts_o
);

  logic [IdWidth-1:0]  want_id;
  logic [LenWidth-1:0] len_limit;

  logic [PosWidth-1:0] pos;
  logic                in_frame;
  logic [3:0]          hi_nib;
  logic [7:0]          run_sum;
  logic                id_bad;
  logic [LenWidth-1:0] len_field;
  logic [7:0]          ctrl_byte;
  logic                sum_ok;

  res_t verdicts_due[$];

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'h0;
  endfunction

  task automatic clear_frame();
    pos = '0;
    hi_nib = '0;
    run_sum = '0;
    id_bad = 1'b0;
    len_field = '0;
    ctrl_byte = '0;
    sum_ok = 1'b0;
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    mismatches_o++;
    if (mismatches_o <= 30) begin
      $display("%0t: %s: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  task automatic track_char(input logic [7:0] c, input logic first);
    logic [PosWidth-1:0] p;
    logic [PosWidth-1:0] cs_pos;
    logic [3:0]          nib;
    logic [7:0]          b;
    logic                done;
    verdict_e            v;
    res_t                r;
    b = 8'h00;
    done = 1'b0;
    v = VerdictOk;
    if (first) begin
      clear_frame();
      in_frame = 1'b1;
    end
    // outside a frame and no start: the character is dropped
    if (in_frame) begin
      p = pos;
      nib = hex_value(c);
      if (!p[0]) hi_nib = nib;
      else b = {hi_nib, nib};
      // offset of the checksum byte once the length is known
      cs_pos = {1'b0, len_field, 1'b0} + 18'd22;
      if (p[0] && (p <= PosLenHi || p < cs_pos)) run_sum = run_sum + b;

      if (p == 18'd0) begin
        if (c != Ch6) begin
          done = 1'b1;
          v = VerdictStart;
        end
      end else if (p == 18'd1) begin
        if (c != Ch8) begin
          done = 1'b1;
          v = VerdictStart;
        end
      end else if (p >= PosIdFirst && p <= PosIdLast) begin
        if (c != want_id[(PosIdLast - p) * 8 +: 8]) id_bad = 1'b1;
      end else if (p == PosRestart0) begin
        if (c != Ch6) begin
          done = 1'b1;
          v = VerdictRestart;
        end
      end else if (p == PosRestart1) begin
        // restart outranks the ID mismatch noted earlier
        if (c != Ch8) begin
          done = 1'b1;
          v = VerdictRestart;
        end else if (id_bad) begin
          done = 1'b1;
          v = VerdictId;
        end
      end else if (p == PosCtrlLo) begin
        ctrl_byte = b;
      end else if (p == PosLenLo) begin
        len_field = {8'h00, b};
      end else if (p == PosLenHi) begin
        len_field = {b, len_field[7:0]};
        if (len_field > len_limit) begin
          done = 1'b1;
          v = VerdictOverload;
        end
      end else if (p >= PosDataStart) begin
        if (p == cs_pos + 18'd1) begin
          sum_ok = (b == run_sum);
        end else if (p == cs_pos + 18'd2) begin
          if (c != Ch1) begin
            done = 1'b1;
            v = VerdictEndCode;
          end
        end else if (p == cs_pos + 18'd3) begin
          // checksum result waits until the end code has passed
          done = 1'b1;
          if (c != Ch6) v = VerdictEndCode;
          else v = sum_ok ? VerdictOk : VerdictChecksum;
        end
      end

      if (done) begin
        in_frame = 1'b0;
        r.verdict = v;
        r.ctrl_code = ctrl_byte;
        r.data_length = len_field;
        verdicts_due.push_back(r);
      end else begin
        pos = p + 18'd1;
      end
    end
  endtask

  task automatic check_result(input logic [31:0] data);
    res_t want;
    verdicts_o++;
    if (verdicts_due.size() == 0) begin
      report("result with no verdict due", data, 32'h0);
    end else begin
      want = verdicts_due.pop_front();
      if (data[2:0] !== want.verdict) begin
        report("verdict", 32'(data[2:0]), 32'(want.verdict));
      end
      if (data[10:3] !== want.ctrl_code) begin
        report("ctrl_code", 32'(data[10:3]), 32'(want.ctrl_code));
      end
      if (data[26:11] !== want.data_length) begin
        report("data_length", 32'(data[26:11]), 32'(want.data_length));
      end
      if (data[31:27] !== 5'd0) report("tdata pad bits", 32'(data[31:27]), 32'h0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_id = '0;
      len_limit = MaxLengthReset;
      in_frame = 1'b0;
      clear_frame();
      verdicts_due.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgExpectedId) want_id = cfg_data_i;
        else len_limit = cfg_data_i[LenWidth-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) track_char(s_axis_tdata, s_axis_tuser);
      pending_o = verdicts_due.size();
    end
  end

endmodule

@@ tb/hex_ascii_meter_frame_checker_test.sv @@
// Testbench top for the frame checker: builds frames, drives the channels and gives the verdict.
module hex_ascii_meter_frame_checker_test;
  import hamfc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 180;
  localparam int PhaseVerdicts = 4;

  typedef enum int {
    FaultNone,
    FaultStart0,
    FaultStart1,
    FaultRestart0,
    FaultRestart1,
    FaultId,
    FaultOverload,
    FaultEnd0,
    FaultEnd1,
    FaultChecksum,
    FaultNonHex,
    FaultTruncate
  } fault_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i   = CfgExpectedId;
  logic [IdWidth-1:0] cfg_data_i    = '0;

  int mismatches;
  int pending;
  int verdicts;
  int src_idle_pct = 16;
  int dst_idle_pct = 86;
  int idle_cycles  = 0;
  int chars_sent   = 0;

  logic [IdWidth-1:0]  cur_id  = '0;
  logic [LenWidth-1:0] cur_max = MaxLengthReset;
  logic [7:0]          frame_q[$];

  hex_ascii_meter_frame_checker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  hex_ascii_meter_frame_checker_scoreboard i_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .verdicts_o    (verdicts)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("hex_ascii_meter_frame_checker_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'h0;
  endfunction

  // hex digit in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] letter;
    letter = $urandom_range(1) ? "a" : "A";
    return (n < 4'd10) ? "0" + n : letter + n - 8'd10;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] avoid);
    logic [7:0] flip;
    flip = 8'($urandom_range(255, 1));
    return avoid ^ flip;
  endfunction

  function automatic fault_e pick_fault();
    fault_e f;
    if ($urandom_range(99) < 40) return FaultNone;
    f = fault_e'($urandom_range(FaultTruncate, FaultStart0));
    if (f == FaultOverload && cur_max == 16'hFFFF) f = FaultNone;
    return f;
  endfunction

  // entered and left at a rising edge
  task automatic send_char(input logic [7:0] c, input logic first);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= first;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    chars_sent++;
  endtask

  // hold the sender until every verdict is out and the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [IdWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [IdWidth-1:0] id, input logic [LenWidth-1:0] limit);
    logic [31:0] noise_hi;
    logic [15:0] noise_lo;
    noise_hi = $urandom;
    noise_lo = 16'($urandom);
    settle();
    write_cfg(CfgExpectedId, id);
    // upper bits of a length write carry junk
    write_cfg(CfgMaxLength, {noise_hi, noise_lo, limit});
    cur_id = id;
    cur_max = limit;
  endtask

  task automatic push_byte(input logic [7:0] b);
    frame_q.push_back(hex_char(b[7:4]));
    frame_q.push_back(hex_char(b[3:0]));
  endtask

  task automatic build_frame(input fault_e fault, input int fixed_len);
    logic [LenWidth-1:0] len;
    logic [7:0]          frame_sum;
    logic [7:0]          c;
    int                  n_data;
    int                  k;
    frame_q.delete();
    frame_q.push_back(Ch6);
    frame_q.push_back(Ch8);
    for (k = 7; k >= 0; k--) frame_q.push_back(cur_id[k*8 +: 8]);
    if (fault == FaultId) begin
      k = $urandom_range(9, 2);
      frame_q[k] = other_than(frame_q[k]);
    end
    // offsets 10..13 are not checked
    for (k = 0; k < 4; k++) begin
      c = ($urandom_range(7) == 0) ? 8'($urandom) : "0";
      frame_q.push_back(c);
    end
    frame_q.push_back(Ch6);
    frame_q.push_back(Ch8);
    c = 8'($urandom);
    push_byte(c);
    if (fixed_len >= 0) len = 16'(fixed_len);
    else if (fault == FaultOverload)
      len = $urandom_range(1) ? cur_max + 16'd1 : 16'($urandom_range(65535, cur_max + 1));
    else if (cur_max <= 100 && $urandom_range(9) == 0) len = cur_max;
    else len = 16'($urandom_range((cur_max < 6) ? cur_max : 6, 0));
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    n_data = (fault == FaultOverload) ? $urandom_range(3) : len;
    for (k = 0; k < n_data; k++) begin
      if (fault == FaultNonHex && $urandom_range(1)) begin
        c = 8'($urandom);
        frame_q.push_back(c);
        c = 8'($urandom);
        frame_q.push_back(c);
      end else begin
        c = 8'($urandom);
        push_byte(c);
      end
    end
    frame_sum = 8'h00;
    for (k = 1; k < frame_q.size(); k += 2)
      frame_sum = frame_sum + {nibble_of(frame_q[k-1]), nibble_of(frame_q[k])};
    if (fault == FaultChecksum) frame_sum = other_than(frame_sum);
    push_byte(frame_sum);
    frame_q.push_back(Ch1);
    frame_q.push_back(Ch6);
    case (fault)
      FaultStart0:   frame_q[0] = other_than(Ch6);
      FaultStart1:   frame_q[1] = other_than(Ch8);
      FaultRestart0: frame_q[PosRestart0] = other_than(Ch6);
      FaultRestart1: frame_q[PosRestart1] = other_than(Ch8);
      FaultEnd0:     frame_q[frame_q.size() - 2] = other_than(Ch1);
      FaultEnd1:     frame_q[frame_q.size() - 1] = other_than(Ch6);
      FaultTruncate: begin
        k = $urandom_range(frame_q.size() - 1, 1);
        while (frame_q.size() > k) frame_q.delete(frame_q.size() - 1);
      end
      default: ;
    endcase
  endtask

  task automatic send_frame(input fault_e fault, input int fixed_len);
    logic [7:0] c;
    int         k;
    build_frame(fault, fixed_len);
    for (k = 0; k < frame_q.size(); k++) send_char(frame_q[k], k == 0);
    // trailing junk: ignored after a verdict, fed into a cut-off frame
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        c = 8'($urandom);
        send_char(c, 1'b0);
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int dst_pct);
    int         items0;
    int         verdicts0;
    logic [7:0] c;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    items0 = chars_sent;
    verdicts0 = verdicts;
    while (chars_sent - items0 < PhaseItems || verdicts - verdicts0 < PhaseVerdicts) begin
      if ($urandom_range(9) == 0) begin
        c = 8'($urandom);
        send_char(c, 1'b1);
      end else begin
        send_frame(pick_fault(), -1);
      end
      if ($urandom_range(15) == 0) settle();
    end
  endtask

  initial begin
    logic [IdWidth-1:0] hex_id;
    logic [IdWidth-1:0] raw_id;
    logic [3:0]         n;
    int                 k;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, stray characters, early start errors, restart mid-frame
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(Ch6, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(Ch6, 1'b1);
    send_char(Ch6, 1'b1);
    send_frame(FaultNone, 0);

    hex_id = '0;
    for (k = 0; k < 8; k++) begin
      n = 4'($urandom);
      hex_id = {hex_id[55:0], hex_char(n)};
    end
    configure(hex_id, 16'($urandom_range(20, 1)));
    run_phase(16, 86);

    configure({IdWidth{1'b1}}, 16'h0000);
    run_phase(86, 16);

    raw_id = {$urandom, $urandom};
    configure(raw_id, 16'hFFFF);
    run_phase(0, 0);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("hex_ascii_meter_frame_checker_test passed");
    end else begin
      $display("hex_ascii_meter_frame_checker_test failed");
    end
    $finish;
  end

endmodule

@@ hex_ascii_meter_frame_checker.f @@
+incdir+rtl
rtl/hamfc_pkg.sv
rtl/hamfc_core.sv
rtl/hex_ascii_meter_frame_checker.sv
rtl/hamfc_checker.sv
tb/hex_ascii_meter_frame_checker_scoreboard.sv
tb/hex_ascii_meter_frame_checker_test.sv
